// File: design/bug1_pkg.sv
// Shared types, widths and constants for the Bug1 wall-follow navigator.
// Used by the controller, the datapath, the square-root unit and the top level.
package bug1_pkg;

    // Field widths.
    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int HEAD_W  = 15;
    localparam int RANGE_W = 16;
    localparam int TOL_W   = 12;
    localparam int LIN_W   = 9;
    localparam int ANG_W   = 10;
    localparam int CFG_IDX_W = 3;

    // Internal datapath widths.
    localparam int SQ_W    = 34;
    localparam int ROOT_W  = 17;
    localparam int CXY_W   = 34;
    localparam int ANGLE_W = 17;
    localparam int ITER_W  = 5;
    localparam int ATAN_N  = 20;

    // CORDIC iteration count default; the angle table gives nonzero entries for indexes 0 to 12.
    localparam int CORDIC_STEPS_DEF = 14;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACE_TOL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_RNG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_RNG = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_RNG = 3'd5;

    // Register reset values.
    localparam logic [TOL_W-1:0]   FACE_TOL_RST = 12'd205;
    localparam logic [RANGE_W-1:0] HIT_RNG_RST  = 16'd256;
    localparam logic [RANGE_W-1:0] NEAR_RNG_RST = 16'd128;
    localparam logic [RANGE_W-1:0] BAND_RNG_RST = 16'd333;

    // Angle and command constants.
    localparam logic signed [ANGLE_W-1:0] PI_Q12 = 17'sd12868;
    localparam logic [LIN_W-1:0] LIN_ONE   = 9'd256;
    localparam logic [LIN_W-1:0] LIN_HALF  = 9'd128;
    localparam logic [LIN_W-1:0] LIN_TENTH = 9'd26;
    localparam logic signed [ANG_W-1:0] ANG_ONE     = 10'sd256;
    localparam logic signed [ANG_W-1:0] ANG_HALF    = 10'sd128;
    localparam logic signed [ANG_W-1:0] ANG_QUARTER = 10'sd64;

    // Follow side codes.
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CINIT,
        S_CRUN,
        S_SQ_C,
        S_ST_C,
        S_WT_C,
        S_SQ_T,
        S_ST_T,
        S_WT_T,
        S_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic cordic_init;
        logic cordic_step;
        logic sq_closest;
        logic sq_pos;
        logic sqrt_start;
        logic save_dc;
        logic commit;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wall_mode;
        logic cordic_last;
        logic sqrt_done;
    } t_ctrl_status;

    // Arctangent table, round(atan(2^-i) * 4096).
    function automatic logic [TOL_W-1:0] atan_q12(input logic [ITER_W-1:0] idx);
        logic [TOL_W-1:0] v;
        case (idx)
            5'd0:    v = 12'd3217;
            5'd1:    v = 12'd1899;
            5'd2:    v = 12'd1003;
            5'd3:    v = 12'd509;
            5'd4:    v = 12'd256;
            5'd5:    v = 12'd128;
            5'd6:    v = 12'd64;
            5'd7:    v = 12'd32;
            5'd8:    v = 12'd16;
            5'd9:    v = 12'd8;
            5'd10:   v = 12'd4;
            5'd11:   v = 12'd2;
            5'd12:   v = 12'd1;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

endpackage

// File: design/bug1_isqrt.sv
// Truncated integer square root, two radicand bits per cycle.
// Depends on bug1_pkg for widths.
module bug1_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bug1_pkg::SQ_W-1:0]   i_value,
    output logic                        o_done,
    output logic [bug1_pkg::ROOT_W-1:0] o_root
);
    import bug1_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic [SQ_W-1:0]   r_val;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ITER_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;

    // Bring down the next pair of bits and try the next root bit.
    assign rem2  = {r_rem[REM_W-3:0], r_val[SQ_W-1 -: 2]};
    assign trial = {r_root, 2'b01};

    // Control: run ROOT_W iterations after each start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= ITER_W'(ROOT_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath of the restoring square root.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[SQ_W-3:0], 2'b00};
            if (rem2 >= trial) begin
                r_rem  <= rem2 - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem2;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: design/bug1_datapath.sv
// Datapath: configuration registers, navigation state, CORDIC bearing,
// squared distances and the step decision. Depends on bug1_pkg and bug1_isqrt.
module bug1_datapath #(
    parameter int CORDIC_STEPS = bug1_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bug1_pkg::t_ctrl_cmd                i_cmd,
    output bug1_pkg::t_ctrl_status             o_status,
    input  logic                               i_cfg_we,
    input  logic [bug1_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bug1_pkg::COORD_W-1:0]       i_cfg_data,
    input  logic signed [bug1_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [bug1_pkg::COORD_W-1:0] i_pos_y,
    input  logic signed [bug1_pkg::HEAD_W-1:0]  i_heading,
    input  logic [bug1_pkg::RANGE_W-1:0]       i_range_left,
    input  logic [bug1_pkg::RANGE_W-1:0]       i_range_front,
    input  logic [bug1_pkg::RANGE_W-1:0]       i_range_right,
    output logic [bug1_pkg::LIN_W-1:0]         o_linear_cmd,
    output logic signed [bug1_pkg::ANG_W-1:0]  o_angular_cmd,
    output logic                               o_following_wall,
    output logic                               o_goal_reached
);
    import bug1_pkg::*;

    // Configuration registers.
    logic signed [COORD_W-1:0] r_tgt_x, r_tgt_y;
    logic [TOL_W-1:0]          r_face_tol;
    logic [RANGE_W-1:0]        r_hit_rng, r_near_rng, r_band_rng;

    // Navigation state.
    logic [1:0]                r_side;
    logic                      r_wall, r_circled;
    logic signed [COORD_W-1:0] r_cls_x, r_cls_y, r_hit_x, r_hit_y;

    // Captured item.
    logic signed [COORD_W-1:0] r_px, r_py;
    logic signed [HEAD_W-1:0]  r_hd;
    logic [RANGE_W-1:0]        r_rl, r_rf, r_rr;

    // CORDIC registers.
    logic signed [CXY_W-1:0]   r_cx, r_cy;
    logic signed [ANGLE_W-1:0] r_cz;
    logic [ITER_W-1:0]         r_iter;
    logic                      r_zero;

    // Squares and distances.
    logic [SQ_W-1:0]   r_sqx, r_sqy;
    logic [ROOT_W-1:0] r_dc;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_x    <= '0;
            r_tgt_y    <= '0;
            r_face_tol <= FACE_TOL_RST;
            r_hit_rng  <= HIT_RNG_RST;
            r_near_rng <= NEAR_RNG_RST;
            r_band_rng <= BAND_RNG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TARGET_X: r_tgt_x    <= i_cfg_data;
                REG_TARGET_Y: r_tgt_y    <= i_cfg_data;
                REG_FACE_TOL: r_face_tol <= i_cfg_data[TOL_W-1:0];
                REG_HIT_RNG:  r_hit_rng  <= i_cfg_data;
                REG_NEAR_RNG: r_near_rng <= i_cfg_data;
                REG_BAND_RNG: r_band_rng <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input capture on the accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_hd <= i_heading;
            r_rl <= i_range_left;
            r_rf <= i_range_front;
            r_rr <= i_range_right;
        end
    end

    // Goal vector from the robot.
    logic signed [DIFF_W-1:0] gdx, gdy;
    assign gdx = DIFF_W'(r_tgt_x) - DIFF_W'(r_px);
    assign gdy = DIFF_W'(r_tgt_y) - DIFF_W'(r_py);

    // CORDIC start vector, scaled by 4096 and folded into the right half plane.
    logic signed [CXY_W-1:0] init_x, init_y, cxs, cys;
    assign init_x = {{(CXY_W-DIFF_W-12){gdx[DIFF_W-1]}}, gdx, 12'b0};
    assign init_y = {{(CXY_W-DIFF_W-12){gdy[DIFF_W-1]}}, gdy, 12'b0};
    assign cxs = r_cx >>> r_iter;
    assign cys = r_cy >>> r_iter;

    // Vectoring CORDIC, one rotation per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_init) begin
            r_iter <= '0;
            r_zero <= (gdx == '0) && (gdy == '0);
            if (gdx[DIFF_W-1]) begin
                r_cx <= -init_x;
                r_cy <= -init_y;
                r_cz <= gdy[DIFF_W-1] ? -PI_Q12 : PI_Q12;
            end else begin
                r_cx <= init_x;
                r_cy <= init_y;
                r_cz <= '0;
            end
        end else if (i_cmd.cordic_step) begin
            r_iter <= r_iter + 1'b1;
            if (!r_cy[CXY_W-1]) begin
                r_cx <= r_cx + cys;
                r_cy <= r_cy - cxs;
                r_cz <= r_cz + ANGLE_W'(atan_q12(r_iter));
            end else begin
                r_cx <= r_cx - cys;
                r_cy <= r_cy + cxs;
                r_cz <= r_cz - ANGLE_W'(atan_q12(r_iter));
            end
        end
    end

    // Squared components toward the goal from the closest point or the robot.
    logic signed [DIFF_W-1:0] sdx, sdy;
    assign sdx = i_cmd.sq_closest ? DIFF_W'(r_tgt_x) - DIFF_W'(r_cls_x) : gdx;
    assign sdy = i_cmd.sq_closest ? DIFF_W'(r_tgt_y) - DIFF_W'(r_cls_y) : gdy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_closest || i_cmd.sq_pos) begin
            r_sqx <= SQ_W'(sdx * sdx);
            r_sqy <= SQ_W'(sdy * sdy);
        end
    end

    bug1_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (r_sqx + r_sqy),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.save_dc) begin
            r_dc <= sqrt_root;
        end
    end

    // Within one metre: each axis differs by at most one, not both at once.
    function automatic logic within_one(input logic signed [DIFF_W-1:0] dx,
                                        input logic signed [DIFF_W-1:0] dy);
        logic ax, ay;
        ax = (dx == '0) || (dx == 17'sd1) || (dx == -17'sd1);
        ay = (dy == '0) || (dy == 17'sd1) || (dy == -17'sd1);
        return ax && ay && ((dx == '0) || (dy == '0));
    endfunction

    // Free step decision.
    logic signed [ANGLE_W-1:0] bearing;
    logic signed [ANGLE_W+1:0] lo_lim, hi_lim, hd_ext, b_ext;
    logic facing;
    assign bearing = r_zero ? '0 : r_cz;
    assign b_ext   = (ANGLE_W+2)'(bearing);
    assign hd_ext  = (ANGLE_W+2)'(r_hd);
    assign lo_lim  = b_ext - (ANGLE_W+2)'({1'b0, r_face_tol});
    assign hi_lim  = b_ext + (ANGLE_W+2)'({1'b0, r_face_tol});
    assign facing  = (lo_lim <= hd_ext) && (hd_ext <= hi_lim);

    // Follow step decision.
    logic                     circ_n, move_cls, exit_ok;
    logic signed [COORD_W-1:0] cls_x_n, cls_y_n;
    logic [RANGE_W-1:0]       side_r;
    logic                     sgn_neg;
    assign circ_n   = r_circled || ((r_dc < sqrt_root) &&
                      within_one(DIFF_W'(r_px) - DIFF_W'(r_hit_x),
                                 DIFF_W'(r_py) - DIFF_W'(r_hit_y)));
    assign move_cls = r_dc > sqrt_root;
    assign cls_x_n  = move_cls ? r_px : r_cls_x;
    assign cls_y_n  = move_cls ? r_py : r_cls_y;
    assign exit_ok  = circ_n && within_one(DIFF_W'(r_px) - DIFF_W'(cls_x_n),
                                           DIFF_W'(r_py) - DIFF_W'(cls_y_n));
    assign sgn_neg  = (r_side == SIDE_RIGHT);
    assign side_r   = sgn_neg ? r_rr : r_rl;

    // Commit: update state and load the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side    <= SIDE_NONE;
            r_wall    <= 1'b0;
            r_circled <= 1'b0;
            r_cls_x   <= '0;
            r_cls_y   <= '0;
            r_hit_x   <= '0;
            r_hit_y   <= '0;
        end else if (i_cmd.commit) begin
            o_goal_reached <= (gdx == '0) && (gdy == '0);
            if (!r_wall) begin
                if (facing && (r_rf <= r_hit_rng)) begin
                    r_side  <= (r_rl < r_rr) ? SIDE_LEFT : SIDE_RIGHT;
                    r_cls_x <= r_px;
                    r_cls_y <= r_py;
                    r_hit_x <= r_px;
                    r_hit_y <= r_py;
                    r_wall  <= 1'b1;
                    o_following_wall <= 1'b1;
                end else begin
                    r_wall <= 1'b0;
                    o_following_wall <= 1'b0;
                end
                if (facing) begin
                    o_linear_cmd  <= LIN_ONE;
                    o_angular_cmd <= '0;
                end else begin
                    o_linear_cmd  <= LIN_HALF;
                    o_angular_cmd <= (b_ext > hd_ext) ? ANG_HALF : -ANG_HALF;
                end
            end else begin
                r_circled <= circ_n;
                r_cls_x   <= cls_x_n;
                r_cls_y   <= cls_y_n;
                if ((r_side == SIDE_LEFT) || (r_side == SIDE_RIGHT)) begin
                    if (exit_ok) begin
                        r_side <= SIDE_NONE;
                        r_wall <= 1'b0;
                        o_following_wall <= 1'b0;
                        o_linear_cmd     <= LIN_ONE;
                        o_angular_cmd    <= sgn_neg ? -ANG_HALF : ANG_HALF;
                    end else begin
                        o_following_wall <= 1'b1;
                        if (side_r <= r_near_rng) begin
                            o_linear_cmd  <= LIN_TENTH;
                            o_angular_cmd <= sgn_neg ? ANG_ONE : -ANG_ONE;
                        end else if (side_r <= r_band_rng) begin
                            o_linear_cmd  <= LIN_HALF;
                            o_angular_cmd <= sgn_neg ? ANG_QUARTER : -ANG_QUARTER;
                        end else begin
                            o_linear_cmd  <= LIN_HALF;
                            o_angular_cmd <= sgn_neg ? -ANG_HALF : ANG_HALF;
                        end
                    end
                end else begin
                    // No valid side: drive straight and leave wall mode.
                    r_wall <= 1'b0;
                    o_following_wall <= 1'b0;
                    o_linear_cmd     <= LIN_ONE;
                    o_angular_cmd    <= '0;
                end
            end
        end
    end

    assign o_status.wall_mode   = r_wall;
    assign o_status.cordic_last = (r_iter == ITER_W'(CORDIC_STEPS - 1));
    assign o_status.sqrt_done   = sqrt_done;

endmodule

// File: design/bug1_ctrl.sv
// Controller state machine: sequences the bearing or the two distances,
// then commits the step and holds the output beat. Depends on bug1_pkg.
module bug1_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  bug1_pkg::t_ctrl_status i_status,
    output bug1_pkg::t_ctrl_cmd    o_cmd
);
    import bug1_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = i_status.wall_mode ? S_SQ_C : S_CINIT;
            S_CINIT: n_state = S_CRUN;
            S_CRUN:  if (i_status.cordic_last) n_state = S_FIN;
            S_SQ_C:  n_state = S_ST_C;
            S_ST_C:  n_state = S_WT_C;
            S_WT_C:  if (i_status.sqrt_done) n_state = S_SQ_T;
            S_SQ_T:  n_state = S_ST_T;
            S_ST_T:  n_state = S_WT_T;
            S_WT_T:  if (i_status.sqrt_done) n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_CINIT: o_cmd.cordic_init = 1'b1;
            S_CRUN:  o_cmd.cordic_step = 1'b1;
            S_SQ_C:  o_cmd.sq_closest  = 1'b1;
            S_ST_C:  o_cmd.sqrt_start  = 1'b1;
            S_WT_C:  o_cmd.save_dc     = i_status.sqrt_done;
            S_SQ_T:  o_cmd.sq_pos      = 1'b1;
            S_ST_T:  o_cmd.sqrt_start  = 1'b1;
            S_WT_T:  ;
            S_FIN:   o_cmd.commit      = out_free;
            default: ;
        endcase
    end

    // Output beat valid: set on commit, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: design/bug1_wall_follow_navigator.sv
// Bug1 wall-follow navigator top level: one navigation step per input beat.
// Channels: input beat (position, heading, three ranges) on i_in_valid/o_in_ready;
// result beat (linear and angular commands, following and goal flags) on
// o_out_valid/i_out_ready; register writes on i_cfg_valid/o_cfg_ready, always ready.
// A free-mode step runs a CORDIC of CORDIC_STEPS rotations; a wall-follow step
// runs two square roots in turn on one shared unit. One item is in work at a time:
// the next beat can be accepted in the cycle after the result register loads.
// The result sits in an output register: if the receiver stalls, the block
// still accepts and computes the next item, then holds in its final state until
// the waiting beat is taken.
// Reset (synchronous, active low) clears all navigation state and restores the
// register defaults; no output beat is pending after reset.
// Depends on bug1_pkg, bug1_ctrl, bug1_datapath and bug1_isqrt.
module bug1_wall_follow_navigator #(
    parameter int CORDIC_STEPS = bug1_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bug1_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bug1_pkg::COORD_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [bug1_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [bug1_pkg::COORD_W-1:0] i_pos_y,
    input  logic signed [bug1_pkg::HEAD_W-1:0]  i_heading,
    input  logic [bug1_pkg::RANGE_W-1:0]        i_range_left,
    input  logic [bug1_pkg::RANGE_W-1:0]        i_range_front,
    input  logic [bug1_pkg::RANGE_W-1:0]        i_range_right,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [bug1_pkg::LIN_W-1:0]          o_linear_cmd,
    output logic signed [bug1_pkg::ANG_W-1:0]   o_angular_cmd,
    output logic                                o_following_wall,
    output logic                                o_goal_reached
);
    import bug1_pkg::*;

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    assign o_cfg_ready = 1'b1;

    bug1_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bug1_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_heading        (i_heading),
        .i_range_left     (i_range_left),
        .i_range_front    (i_range_front),
        .i_range_right    (i_range_right),
        .o_linear_cmd     (o_linear_cmd),
        .o_angular_cmd    (o_angular_cmd),
        .o_following_wall (o_following_wall),
        .o_goal_reached   (o_goal_reached)
    );

`ifndef ASSERT_OFF
    // Only one item is in work: after an accepted beat the input is not ready.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item is in work");

    // The forward command never exceeds full speed.
    a_lin_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_linear_cmd <= LIN_ONE))
        else $error("linear command above full speed");

    // Full speed with a turn only happens when leaving the wall.
    a_exit_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_linear_cmd == LIN_ONE) && (o_angular_cmd != '0))
            |-> !o_following_wall)
        else $error("full speed turn while still following the wall");
`endif

endmodule

// File: tb/sv/bug1_wall_follow_navigator_tb.sv
// Self-checking testbench for the Bug1 wall-follow navigator.
// Depends on bug1_pkg and the bug1_wall_follow_navigator top level; a scoreboard
// class predicts every result beat from the accepted input beats.
module bug1_wall_follow_navigator_tb;
    import bug1_pkg::*;

    localparam int STEPS      = CORDIC_STEPS_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_PHASES   = 8;
    localparam int PHASE_LEN  = 175;

    // One expected result beat.
    typedef struct {
        logic [LIN_W-1:0]        lin;
        logic signed [ANG_W-1:0] ang;
        logic                    follow;
        logic                    goal;
    } nav_cmd_t;

    // Navigation predictor and store of expected command beats.
    class nav_scoreboard;
        int         tgt_x, tgt_y, tol, hit_rng, near_rng, band_rng;
        logic [1:0] side;
        bit         wall, circled;
        int         cls_x, cls_y, hit_x, hit_y;
        nav_cmd_t   pending_cmds[$];
        int         errors;

        function new();
            tgt_x = 0; tgt_y = 0;
            tol = FACE_TOL_RST; hit_rng = HIT_RNG_RST;
            near_rng = NEAR_RNG_RST; band_rng = BAND_RNG_RST;
            side = SIDE_NONE; wall = 0; circled = 0;
            cls_x = 0; cls_y = 0; hit_x = 0; hit_y = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
            case (idx)
                REG_TARGET_X: tgt_x = $signed(data);
                REG_TARGET_Y: tgt_y = $signed(data);
                REG_FACE_TOL: tol = data[TOL_W-1:0];
                REG_HIT_RNG:  hit_rng = data;
                REG_NEAR_RNG: near_rng = data;
                REG_BAND_RNG: band_rng = data;
                default: ;
            endcase
        endfunction

        function longint unsigned sq_dist(int ax, int ay, int bx, int by);
            longint dx, dy;
            dx = longint'(ax) - bx;
            dy = longint'(ay) - by;
            return longint'(dx * dx) + longint'(dy * dy);
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // Goal bearing by vectoring rotations, Q3.12 radians.
        function int goal_bearing(int px, int py);
            int     atab[20];
            longint x, y, z, xs, ys;
            atab = '{3217, 1899, 1003, 509, 256, 128, 64, 32, 16, 8,
                     4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
            x = longint'(tgt_x) - px;
            y = longint'(tgt_y) - py;
            z = 0;
            if (x == 0 && y == 0) return 0;
            x = x * 4096;
            y = y * 4096;
            if (x < 0) begin
                z = (y >= 0) ? 12868 : -12868;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys; y = y - xs; z = z + atab[i];
                end else begin
                    x = x - ys; y = y + xs; z = z - atab[i];
                end
            end
            return int'(z);
        endfunction

        // Advance the navigation state by one accepted beat and queue its result.
        function void note_input(int px, int py, int hd, int rl, int rf, int rr);
            int              b, lin, ang, side_r, sgn;
            bit              facing;
            longint unsigned dc, dt;
            nav_cmd_t        c;
            lin = 0;
            ang = 0;
            if (!wall) begin
                b = goal_bearing(px, py);
                facing = (b - tol <= hd) && (hd <= b + tol);
                if (facing && rf <= hit_rng) begin
                    side = (rl < rr) ? SIDE_LEFT : SIDE_RIGHT;
                    cls_x = px; cls_y = py; hit_x = px; hit_y = py;
                    wall = 1;
                end
                if (!facing) begin
                    lin = 128;
                    ang = (b > hd) ? 128 : -128;
                end else begin
                    lin = 256;
                end
            end else begin
                dc = int_root(sq_dist(tgt_x, tgt_y, cls_x, cls_y));
                dt = int_root(sq_dist(tgt_x, tgt_y, px, py));
                if (dc < dt && sq_dist(px, py, hit_x, hit_y) <= 1) circled = 1;
                if (dc > dt) begin
                    cls_x = px; cls_y = py;
                end
                if (side == SIDE_LEFT || side == SIDE_RIGHT) begin
                    side_r = (side == SIDE_LEFT) ? rl : rr;
                    sgn = (side == SIDE_LEFT) ? 1 : -1;
                    if (circled && sq_dist(px, py, cls_x, cls_y) <= 1) begin
                        side = SIDE_NONE;
                        wall = 0;
                        ang = sgn * 128; lin = 256;
                    end else if (side_r <= near_rng) begin
                        ang = -sgn * 256; lin = 26;
                    end else if (side_r <= band_rng) begin
                        ang = -sgn * 64; lin = 128;
                    end else begin
                        ang = sgn * 128; lin = 128;
                    end
                end else begin
                    // An unknown side code behaves as free driving.
                    lin = 256;
                    wall = 0;
                end
            end
            c.lin = lin[LIN_W-1:0];
            c.ang = ang[ANG_W-1:0];
            c.follow = wall;
            c.goal = (sq_dist(tgt_x, tgt_y, px, py) == 0);
            pending_cmds.push_back(c);
        endfunction

        function void check_result(logic [LIN_W-1:0] lin, logic signed [ANG_W-1:0] ang,
                                   logic follow, logic goal);
            nav_cmd_t e;
            if (pending_cmds.size() == 0) begin
                $display("%0t: result beat with none expected", $time);
                errors++;
                return;
            end
            e = pending_cmds.pop_front();
            if (lin !== e.lin) begin
                $display("%0t: linear_cmd expected %0d actual %0d", $time, e.lin, lin);
                errors++;
            end
            if (ang !== e.ang) begin
                $display("%0t: angular_cmd expected %0d actual %0d", $time, e.ang, ang);
                errors++;
            end
            if (follow !== e.follow) begin
                $display("%0t: following_wall expected %0d actual %0d", $time, e.follow,
                         follow);
                errors++;
            end
            if (goal !== e.goal) begin
                $display("%0t: goal_reached expected %0d actual %0d", $time, e.goal, goal);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [COORD_W-1:0]          i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic signed [COORD_W-1:0]   i_pos_x;
    logic signed [COORD_W-1:0]   i_pos_y;
    logic signed [HEAD_W-1:0]    i_heading;
    logic [RANGE_W-1:0]          i_range_left;
    logic [RANGE_W-1:0]          i_range_front;
    logic [RANGE_W-1:0]          i_range_right;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [LIN_W-1:0]            o_linear_cmd;
    logic signed [ANG_W-1:0]     o_angular_cmd;
    logic                        o_following_wall;
    logic                        o_goal_reached;

    nav_scoreboard nav_sb;
    bit            no_idle;
    int            ready_hold;
    int            quiet_cycles;

    bug1_wall_follow_navigator dut (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result monitor and command checks; results are checked before new beats are noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                nav_sb.check_result(o_linear_cmd, o_angular_cmd, o_following_wall,
                                    o_goal_reached);
            if (i_in_valid && o_in_ready)
                nav_sb.note_input(i_pos_x, i_pos_y, i_heading, i_range_left,
                                  i_range_front, i_range_right);
        end
    end

    // Receiver: a random stall, or none in no-idle stretches, is drawn after every result beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ready_hold = 0;
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                ready_hold = no_idle ? 0 : $urandom_range(0, 7);
            else if (ready_hold > 0)
                ready_hold--;
            i_out_ready <= (ready_hold == 0);
        end
    end

    // Watchdog on cycles without any beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one input beat; valid stays high when no gap follows.
    task automatic send_beat(int px, int py, int hd, int rl, int rf, int rr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_pos_x       <= px[COORD_W-1:0];
        i_pos_y       <= py[COORD_W-1:0];
        i_heading     <= hd[HEAD_W-1:0];
        i_range_left  <= rl[RANGE_W-1:0];
        i_range_front <= rf[RANGE_W-1:0];
        i_range_right <= rr[RANGE_W-1:0];
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Let every expected result drain, then allow the block to settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (nav_sb.pending_cmds.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        nav_sb.write_reg(idx, data);
    endtask

    function automatic int pick_range(int lo, int hi);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 65535;
            2: return lo;
            3: return hi;
            default: return $urandom_range(0, hi + 400 > 65535 ? 65535 : hi + 400);
        endcase
    endfunction

    // Random phase: a walk around the goal with mostly goal-facing headings.
    task automatic run_walk(int n);
        int px, py, hd, b, rl, rf, rr, lo, hi, t;
        px = nav_sb.tgt_x + $urandom_range(0, 12) - 6;
        py = nav_sb.tgt_y + $urandom_range(0, 12) - 6;
        for (int k = 0; k < n; k++) begin
            if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            t = $urandom_range(0, 99);
            if (t < 3) begin
                px = $signed(16'($urandom));
                py = $signed(16'($urandom));
            end else if (t < 12) begin
                px = nav_sb.tgt_x + $urandom_range(0, 16) - 8;
                py = nav_sb.tgt_y + $urandom_range(0, 16) - 8;
            end else if (t < 30 && nav_sb.wall) begin
                // Come back by the hit point so the circuit can close.
                px = nav_sb.hit_x + $urandom_range(0, 2) - 1;
                py = nav_sb.hit_y + $urandom_range(0, 2) - 1;
            end else if (t < 38 && nav_sb.wall && nav_sb.circled) begin
                px = nav_sb.cls_x;
                py = nav_sb.cls_y;
            end else begin
                px = px + $urandom_range(0, 2) - 1;
                py = py + $urandom_range(0, 2) - 1;
            end
            px = $signed(16'(px));
            py = $signed(16'(py));
            b = nav_sb.goal_bearing(px, py);
            if ($urandom_range(0, 9) < 6)
                hd = b + $urandom_range(0, 2 * nav_sb.tol) - nav_sb.tol;
            else
                hd = $urandom_range(0, 25736) - 12868;
            if ($urandom_range(0, 19) == 0) hd = $signed(15'($urandom));
            if (hd > 16383) hd = 16383;
            if (hd < -16384) hd = -16384;
            rf = ($urandom_range(0, 9) < 5) ? $urandom_range(0, nav_sb.hit_rng)
                                           : $urandom_range(0, 65535);
            lo = nav_sb.near_rng;
            hi = nav_sb.band_rng;
            rl = pick_range(lo, hi);
            rr = pick_range(lo, hi);
            send_beat(px, py, hd, rl, rf, rr);
        end
        no_idle = 0;
    endtask

    initial begin
        int tx, ty, tl, hr, nr, br;
        nav_sb        = new();
        no_idle       = 0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_heading     = '0;
        i_range_left  = '0;
        i_range_front = '0;
        i_range_right = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: goal, field extremes, left follow to a full circuit, right follow.
        send_beat(0, 0, 0, 65535, 65535, 65535);
        send_beat(-32768, -32768, -16384, 0, 65535, 65535);
        send_beat(32767, 32767, 16383, 65535, 65535, 0);
        send_beat(32767, -32768, 12868, 0, 0, 0);
        send_beat(-5, 0, 0, 50, 100, 200);
        send_beat(-5, 1, 0, 50, 65535, 0);
        send_beat(-4, 1, 0, 200, 65535, 0);
        send_beat(-4, 2, 0, 1000, 65535, 0);
        send_beat(-5, 0, 0, 1000, 65535, 0);
        send_beat(-4, 1, 0, 1000, 65535, 0);
        send_beat(-6, 0, 0, 300, 0, 100);
        send_beat(-6, 0, 0, 300, 0, 100);
        send_beat(-6, 1, 0, 300, 0, 50);
        send_beat(-5, 1, 0, 300, 0, 200);
        send_beat(-5, 2, 0, 300, 0, 5000);
        send_beat(0, 0, -12868, 0, 0, 0);
        drain_results();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin tx = 32767;  ty = -32768; tl = 4095; hr = 65535; nr = 0;
                         br = 65535; end
                1: begin tx = -32768; ty = 32767;  tl = 0;    hr = 0;     nr = 65535;
                         br = 0; end
                2: begin tx = 0;      ty = 0;      tl = 205;  hr = 256;   nr = 128;
                         br = 333; end
                default: begin
                    tx = $urandom_range(0, 40) - 20;
                    ty = $urandom_range(0, 40) - 20;
                    tl = $urandom_range(0, 4095);
                    hr = $urandom_range(0, 1024);
                    nr = $urandom_range(0, 400);
                    br = nr + $urandom_range(0, 400);
                end
            endcase
            write_reg(REG_TARGET_X, tx[COORD_W-1:0]);
            write_reg(REG_TARGET_Y, ty[COORD_W-1:0]);
            write_reg(REG_FACE_TOL, (ph == 0) ? 16'hFFFF : tl[COORD_W-1:0]);
            write_reg(REG_HIT_RNG,  hr[COORD_W-1:0]);
            write_reg(REG_NEAR_RNG, nr[COORD_W-1:0]);
            write_reg(REG_BAND_RNG, br[COORD_W-1:0]);
            run_walk(PHASE_LEN);
            drain_results();
        end

        if (nav_sb.errors == 0 && nav_sb.pending_cmds.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
